// File: hw/rtl/bilinear_texel_sampler_assert.svh
// Assertion macros used by the sampler top level.
`ifndef BILINEAR_TEXEL_SAMPLER_ASSERT_SVH
`define BILINEAR_TEXEL_SAMPLER_ASSERT_SVH
// Implication checked in the same cycle.
`define BTX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication checked in the next cycle.
`define BTX_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/btx_pkg.sv
// Shared types and constants of the bilinear texel sampler.
`timescale 1ns / 1ps
package btx_pkg;
   localparam int ADDR_W   = 18;
   localparam int TEX_BYTES = 262144;
   localparam int NREAD    = 12;
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PITCH  = 2'd2;
   localparam logic [1:0] REG_PIXEL  = 2'd3;
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic [10:0] tex_width;
      logic [10:0] tex_height;
      logic [12:0] row_pitch;
      logic [2:0]  pixel_bytes;
   } btx_cfg_type;

   typedef struct packed {
      logic                              valid;
      logic                              wr;
      logic [ADDR_W-1:0]                 wr_addr;
      logic [7:0]                        wr_byte;
      logic [NREAD-1:0][ADDR_W-1:0]      addr;
      logic [3:0][32:0]                  weight;
   } btx_fetch_type;
endpackage

// File: hw/rtl/btx_ram.sv
// Generic byte store: one write port, two registered read ports.
`timescale 1ns / 1ps
module btx_ram #(
   parameter int AW = 18,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] wa,
   input  logic [DW-1:0] wd,
   input  logic          re,
   input  logic [AW-1:0] ra0,
   input  logic [AW-1:0] ra1,
   output logic [DW-1:0] rd0,
   output logic [DW-1:0] rd1
);
   logic [DW-1:0] mem [(2**AW)-1:0];
   logic [DW-1:0] rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
   end
   always_ff @(posedge clock) begin
      if (re) begin
         rd0_ff <= mem[ra0];
         rd1_ff <= mem[ra1];
      end
   end
   assign rd0 = rd0_ff;
   assign rd1 = rd1_ff;
endmodule

// File: hw/rtl/btx_addr.sv
// Coordinate scaling, edge clamp, texel addresses and bilinear weights.
`timescale 1ns / 1ps
module btx_addr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic                  in_type,
   input  logic [17:0]           in_waddr,
   input  logic [7:0]            in_wbyte,
   input  logic [16:0]           in_u,
   input  logic [16:0]           in_v,
   input  btx_pkg::btx_cfg_type  cfg,
   output btx_pkg::btx_fetch_type fetch
);
   typedef struct packed {
      logic [10:0] i0;
      logic [10:0] i1;
      logic [16:0] frac;
   } btx_axis_type;

   function automatic btx_axis_type axis(input logic [27:0] pos, input logic [10:0] n);
      logic [10:0]  nm1;
      logic [10:0]  i0c;
      logic [27:0]  fr;
      logic [11:0]  ip1;
      btx_axis_type r;
      nm1 = n - 11'd1;
      i0c = (pos[27:16] > {1'b0, nm1}) ? nm1 : pos[26:16];
      fr  = pos - {1'b0, i0c, 16'h0000};
      r.frac = (fr > 28'd65536) ? 17'd65536 : fr[16:0];
      ip1 = {1'b0, i0c} + 12'd1;
      r.i1 = (ip1 > {1'b0, nm1}) ? nm1 : ip1[10:0];
      r.i0 = i0c;
      return r;
   endfunction

   logic [10:0] n_w, n_h;
   assign n_w = (cfg.tex_width == 11'd0) ? 11'd1 : cfg.tex_width;
   assign n_h = (cfg.tex_height == 11'd0) ? 11'd1 : cfg.tex_height;

   // stage valids: [0] sample, [1] write
   logic [1:0] a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff;
   logic [17:0] a_wa_ff, b_wa_ff, c_wa_ff, d_wa_ff, e_wa_ff;
   logic [7:0]  a_wb_ff, b_wb_ff, c_wb_ff, d_wb_ff, e_wb_ff;
   logic [16:0] a_u_ff, a_v_coord_ff;
   logic [27:0] b_px_ff, b_py_ff;
   btx_axis_type c_x_ff, c_y_ff, ax_x_in, ax_y_in;
   logic [23:0] d_yr0_ff, d_yr1_ff;
   logic [13:0] d_xp0_ff, d_xp1_ff;
   logic [3:0][32:0] d_w_ff, d_w_in, e_w_ff;
   logic [btx_pkg::NREAD-1:0][17:0] e_addr_ff, e_addr_in;
   logic [16:0] kxn, kyn;
   logic [33:0] p00, p01, p10, p11;
   logic [24:0] base [3:0];

   assign ax_x_in = axis(b_px_ff, n_w);
   assign ax_y_in = axis(b_py_ff, n_h);

   assign kxn = 17'd65536 - c_x_ff.frac;
   assign kyn = 17'd65536 - c_y_ff.frac;
   assign p00 = kxn * kyn;
   assign p01 = c_x_ff.frac * kyn;
   assign p10 = kxn * c_y_ff.frac;
   assign p11 = c_x_ff.frac * c_y_ff.frac;
   assign d_w_in[0] = p00[32:0];
   assign d_w_in[1] = p01[32:0];
   assign d_w_in[2] = p10[32:0];
   assign d_w_in[3] = p11[32:0];

   assign base[0] = {1'b0, d_yr0_ff} + {11'd0, d_xp0_ff};
   assign base[1] = {1'b0, d_yr0_ff} + {11'd0, d_xp1_ff};
   assign base[2] = {1'b0, d_yr1_ff} + {11'd0, d_xp0_ff};
   assign base[3] = {1'b0, d_yr1_ff} + {11'd0, d_xp1_ff};

   always_comb begin
      logic [24:0] s;
      for (int k = 0; k < 4; k++) begin
         for (int o = 0; o < 3; o++) begin
            s = base[k] + 25'(o);
            e_addr_in[k*3+o] = s[17:0];   // wraps modulo store size
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 2'b00;
         b_v_ff <= 2'b00;
         c_v_ff <= 2'b00;
         d_v_ff <= 2'b00;
         e_v_ff <= 2'b00;
      end else if (adv) begin
         a_v_ff <= {in_valid && (in_type == btx_pkg::REQ_WRITE),
                    in_valid && (in_type == btx_pkg::REQ_SAMPLE)};
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_wa_ff <= in_waddr;
         a_wb_ff <= in_wbyte;
         a_u_ff <= in_u;
         a_v_coord_ff <= in_v;
         b_wa_ff <= a_wa_ff;
         b_wb_ff <= a_wb_ff;
         b_px_ff <= a_u_ff * n_w;
         b_py_ff <= a_v_coord_ff * n_h;
         c_wa_ff <= b_wa_ff;
         c_wb_ff <= b_wb_ff;
         c_x_ff <= ax_x_in;
         c_y_ff <= ax_y_in;
         d_wa_ff <= c_wa_ff;
         d_wb_ff <= c_wb_ff;
         d_yr0_ff <= c_y_ff.i0 * cfg.row_pitch;
         d_yr1_ff <= c_y_ff.i1 * cfg.row_pitch;
         d_xp0_ff <= c_x_ff.i0 * cfg.pixel_bytes;
         d_xp1_ff <= c_x_ff.i1 * cfg.pixel_bytes;
         d_w_ff <= d_w_in;
         e_wa_ff <= d_wa_ff;
         e_wb_ff <= d_wb_ff;
         e_addr_ff <= e_addr_in;
         e_w_ff <= d_w_ff;
      end
   end

   assign fetch.valid   = e_v_ff[0];
   assign fetch.wr      = e_v_ff[1];
   assign fetch.wr_addr = e_wa_ff;
   assign fetch.wr_byte = e_wb_ff;
   assign fetch.addr    = e_addr_ff;
   assign fetch.weight  = e_w_ff;
endmodule

// File: hw/rtl/btx_blend.sv
// Weighted sum of four texels and rounded scaling to Q1.16.
`timescale 1ns / 1ps
module btx_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic [3:0][32:0]                in_weight,
   input  logic [btx_pkg::NREAD-1:0][7:0]  texel,
   output logic                            out_valid,
   output logic [2:0][16:0]                out_rgb
);
   localparam logic [40:0] HALF  = 41'd8355840;   // half of 255 << 16
   localparam logic [24:0] RECIP = 25'd16843009;  // floor(2^32 / 255)

   logic f_v_ff, g_v_ff, h_v_ff, i_v_ff, j_v_ff;
   logic [3:0][32:0] f_w_ff;
   logic [btx_pkg::NREAD-1:0][40:0] g_p_ff, g_p_in;
   logic [2:0][40:0] h_s_ff, h_s_in;
   logic [2:0][24:0] i_t_ff;
   logic [2:0][49:0] i_m_ff;
   logic [2:0][16:0] j_q_ff, j_q_in;

   always_comb begin
      for (int k = 0; k < 4; k++)
         for (int o = 0; o < 3; o++)
            g_p_in[k*3+o] = texel[k*3+o] * f_w_ff[k];
   end

   always_comb begin
      for (int o = 0; o < 3; o++)
         h_s_in[o] = g_p_ff[o] + g_p_ff[3+o] + g_p_ff[6+o] + g_p_ff[9+o] + HALF;
   end

   always_comb begin
      logic [17:0] q0;
      logic [25:0] rem;
      for (int o = 0; o < 3; o++) begin
         q0 = i_m_ff[o][49:32];
         rem = {1'b0, i_t_ff[o]} - ({q0, 8'h00} - {8'h00, q0});
         j_q_in[o] = (rem >= 26'd255) ? q0[16:0] + 17'd1 : q0[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= in_valid;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
         i_v_ff <= h_v_ff;
         j_v_ff <= i_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_w_ff <= in_weight;
         g_p_ff <= g_p_in;
         h_s_ff <= h_s_in;
         for (int o = 0; o < 3; o++) begin
            i_t_ff[o] <= h_s_ff[o][40:16];
            i_m_ff[o] <= h_s_ff[o][40:16] * RECIP;
         end
         j_q_ff <= j_q_in;
      end
   end

   assign out_valid = j_v_ff;
   assign out_rgb   = j_q_ff;
endmodule

// File: hw/rtl/bilinear_texel_sampler.sv
// Bilinear texel sampler: top level with register port and texture store.
// A sample passes address stages a to e, then the store read alongside blend stage f, then g to j.
// Throughput: one request per cycle while the result side does not stall, writes and
// samples alike; the store is replicated six times so the twelve byte reads of a sample
// happen in the same cycle. A stall on the result side holds the whole pipeline in place.
// Reset (synchronous) clears valids and sets config defaults; store contents undefined.
`timescale 1ns / 1ps
`include "bilinear_texel_sampler_assert.svh"
module bilinear_texel_sampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // write_addr, write_byte, coord_u, coord_v, zero pad
   input  logic [0:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // red, green, blue, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   btx_pkg::btx_cfg_type cfg_ff;
   btx_pkg::btx_fetch_type fetch;
   logic adv;
   logic [btx_pkg::NREAD-1:0][7:0] texel;
   logic [2:0][16:0] rgb;

   assign csr_pready = 1'b1;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width   <= 11'd1;
         cfg_ff.tex_height  <= 11'd1;
         cfg_ff.row_pitch   <= 13'd4;
         cfg_ff.pixel_bytes <= 3'd3;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            btx_pkg::REG_WIDTH:  cfg_ff.tex_width   <= csr_pwdata[10:0];
            btx_pkg::REG_HEIGHT: cfg_ff.tex_height  <= csr_pwdata[10:0];
            btx_pkg::REG_PITCH:  cfg_ff.row_pitch   <= csr_pwdata[12:0];
            btx_pkg::REG_PIXEL:  cfg_ff.pixel_bytes <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         btx_pkg::REG_WIDTH:  csr_prdata = {21'd0, cfg_ff.tex_width};
         btx_pkg::REG_HEIGHT: csr_prdata = {21'd0, cfg_ff.tex_height};
         btx_pkg::REG_PITCH:  csr_prdata = {19'd0, cfg_ff.row_pitch};
         btx_pkg::REG_PIXEL:  csr_prdata = {29'd0, cfg_ff.pixel_bytes};
         default:             csr_prdata = 32'd0;
      endcase
   end

   btx_addr u_addr (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .in_type  (req_tuser[0]),
      .in_waddr (req_tdata[17:0]),
      .in_wbyte (req_tdata[25:18]),
      .in_u     (req_tdata[42:26]),
      .in_v     (req_tdata[59:43]),
      .cfg      (cfg_ff),
      .fetch    (fetch)
   );

   // Writes and reads both happen on the stage advance, so request order holds.
   for (genvar c = 0; c < btx_pkg::NREAD / 2; c++) begin : g_bank
      btx_ram #(.AW(btx_pkg::ADDR_W), .DW(8)) u_ram (
         .clock (clock),
         .we    (adv && fetch.wr),
         .wa    (fetch.wr_addr),
         .wd    (fetch.wr_byte),
         .re    (adv),
         .ra0   (fetch.addr[2*c]),
         .ra1   (fetch.addr[2*c+1]),
         .rd0   (texel[2*c]),
         .rd1   (texel[2*c+1])
      );
   end

   btx_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fetch.valid),
      .in_weight (fetch.weight),
      .texel     (texel),
      .out_valid (rsp_tvalid),
      .out_rgb   (rgb)
   );

   // rgb is indexed by byte offset: blue 0, green 1, red 2
   assign rsp_tdata = {5'd0, rgb[0], rgb[1], rgb[2]};

   `BTX_ASSERT_NOW(a_wr_no_sample, clock, reset, fetch.wr, !fetch.valid)
   `BTX_ASSERT_NOW(a_red_range, clock, reset, rsp_tvalid, rgb[2] <= 17'd65536)
   `BTX_ASSERT_NOW(a_blue_range, clock, reset, rsp_tvalid, rgb[0] <= 17'd65536)
   `BTX_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_tvalid && !fetch.valid && !fetch.wr)
endmodule

// File: sim/bilinear_texel_sampler_tb.sv
// Self-checking testbench for the bilinear texel sampler: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps
module bilinear_texel_sampler_tb;

   typedef struct {
      logic        kind;
      logic [17:0] addr;
      logic [7:0]  data;
      logic [16:0] u;
      logic [16:0] v;
   } tex_req_type;

   typedef struct {
      logic [16:0] red;
      logic [16:0] green;
      logic [16:0] blue;
   } texel_rgb_type;

   localparam int NPHASE     = 7;
   localparam int RAND_ITEMS = 190;
   localparam int WD_LIMIT   = 6000;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN      = 14;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bilinear_texel_sampler u_top (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [7:0]  tex_mem [0:btx_pkg::TEX_BYTES-1];
   logic [10:0] cfg_width, cfg_height;
   logic [12:0] cfg_pitch;
   logic [2:0]  cfg_pixel;

   tex_req_type   pend_q[$];
   texel_rgb_type rgb_q[$];
   tex_req_type   cur_req;

   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0, n_writes = 0, n_samples = 0, n_results = 0;
   bit hold_start = 0, hold_active = 0;
   int hold_cnt = 0, wd_cnt = 0;
   bit done = 0;

   task automatic report_mismatch(input string what, input logic [16:0] exp_v,
                                  input logic [16:0] got_v);
      $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
      errors++;
   endtask

   // one axis: clamp-to-edge index pair and the weight of the far texel
   function automatic void texel_axis(input logic [16:0] coord, input logic [10:0] size,
                                      output longint unsigned i0, output longint unsigned i1,
                                      output longint unsigned f);
      longint unsigned n, pos;
      n   = (size == 0) ? 1 : size;
      pos = coord * n;
      i0  = pos >> 16;
      if (i0 > n - 1) i0 = n - 1;
      f = pos - (i0 << 16);
      if (f > 65536) f = 65536;
      i1 = (i0 + 1 > n - 1) ? n - 1 : i0 + 1;
   endfunction

   function automatic texel_rgb_type blend_texels(input logic [16:0] u, input logic [16:0] v);
      longint unsigned x0, x1, y0, y1, kx, ky, sum;
      longint unsigned base[4], w[4];
      texel_rgb_type r;
      logic [16:0] ch[3];
      texel_axis(u, cfg_width, x0, x1, kx);
      texel_axis(v, cfg_height, y0, y1, ky);
      base[0] = y0 * cfg_pitch + x0 * cfg_pixel;
      base[1] = y0 * cfg_pitch + x1 * cfg_pixel;
      base[2] = y1 * cfg_pitch + x0 * cfg_pixel;
      base[3] = y1 * cfg_pitch + x1 * cfg_pixel;
      w[0] = (65536 - kx) * (65536 - ky);
      w[1] = kx * (65536 - ky);
      w[2] = (65536 - kx) * ky;
      w[3] = kx * ky;
      for (int c = 0; c < 3; c++) begin
         sum = 0;
         for (int k = 0; k < 4; k++)
            sum += tex_mem[(base[k] + 2 - c) % btx_pkg::TEX_BYTES] * w[k];
         // Q.32 sum scaled by 65536/255, halves rounded up
         ch[c] = 17'((sum + 64'd8355840) / 64'd16711680);
      end
      r.red = ch[0]; r.green = ch[1]; r.blue = ch[2];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      logic          nvalid;
      texel_rgb_type e;
      nvalid = req_tvalid;
      if (reset) begin
         nvalid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_req.kind == btx_pkg::REQ_WRITE) begin
               tex_mem[cur_req.addr] = cur_req.data;
               n_writes++;
            end else begin
               e = blend_texels(cur_req.u, cur_req.v);
               rgb_q.push_back(e);
               n_samples++;
            end
         end
         if (!req_tvalid || req_tready) begin
            nvalid = 1'b0;
            if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = pend_q.pop_front();
               req_tdata <= {4'b0, cur_req.v, cur_req.u, cur_req.data, cur_req.addr};
               req_tuser <= cur_req.kind;
               nvalid = 1'b1;
            end
         end
      end
      req_tvalid <= nvalid;
   end

   // monitor and receiver backpressure
   always @(posedge clock) begin
      texel_rgb_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (rgb_q.size() == 0) begin
            report_mismatch("unexpected result", 17'd0, rsp_tdata[16:0]);
         end else begin
            e = rgb_q.pop_front();
            if (rsp_tdata[16:0] !== e.red)    report_mismatch("red", e.red, rsp_tdata[16:0]);
            if (rsp_tdata[33:17] !== e.green)
               report_mismatch("green", e.green, rsp_tdata[33:17]);
            if (rsp_tdata[50:34] !== e.blue)
               report_mismatch("blue", e.blue, rsp_tdata[50:34]);
         end
      end
      if (hold_start && !hold_active && hold_cnt == 0) begin
         hold_active = 1;
         hold_cnt = HOLD_LEN;
      end
      if (hold_active) begin
         hold_cnt--;
         if (hold_cnt == 0) begin
            hold_active = 0;
            hold_start = 0;
         end
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || done || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || csr_psel)
         wd_cnt <= 0;
      else if (wd_cnt >= WD_LIMIT) begin
         $display("watchdog expired at %0t", $realtime);
         $display("bilinear_texel_sampler test failed");
         $finish;
      end else
         wd_cnt <= wd_cnt + 1;
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         btx_pkg::REG_WIDTH:  cfg_width  = value[10:0];
         btx_pkg::REG_HEIGHT: cfg_height = value[10:0];
         btx_pkg::REG_PITCH:  cfg_pitch  = value[12:0];
         default:             cfg_pixel  = value[2:0];
      endcase
   endtask

   function automatic tex_req_type mk_write(input logic [17:0] a, input logic [7:0] d);
      tex_req_type t;
      t.kind = btx_pkg::REQ_WRITE; t.addr = a; t.data = d;
      t.u = 17'($urandom); t.v = 17'($urandom);
      return t;
   endfunction

   function automatic tex_req_type mk_sample(input logic [16:0] u, input logic [16:0] v);
      tex_req_type t;
      t.kind = btx_pkg::REQ_SAMPLE; t.u = u; t.v = v;
      t.addr = 18'($urandom); t.data = 8'($urandom);
      return t;
   endfunction

   function automatic logic [16:0] rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return 17'd0;
      if (r < 16) return 17'd65536;
      if (r < 24) return 17'($urandom_range(131071, 65537));
      return 17'($urandom_range(65536));
   endfunction

   int ph_w[NPHASE] = '{1, 4, 40, 0, 7, 2047, 8};
   int ph_h[NPHASE] = '{1, 4, 1024, 2047, 3, 0, 8};
   int ph_p[NPHASE] = '{4, 12, 0, 0, 100, 8191, 32};
   int ph_b[NPHASE] = '{3, 3, 3, 1, 7, 0, 4};

   initial begin
      int region;
      cfg_width = 1; cfg_height = 1; cfg_pitch = 4; cfg_pixel = 3;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NPHASE; ph++) begin
         while (pend_q.size() > 0 || req_tvalid || rgb_q.size() > 0) @(posedge clock);
         repeat (DRAIN) @(posedge clock);
         // first phase runs on the reset values
         if (ph > 0) begin
            csr_write(btx_pkg::REG_WIDTH,  {$urandom} << 11 | ph_w[ph]);
            csr_write(btx_pkg::REG_HEIGHT, {$urandom} << 11 | ph_h[ph]);
            csr_write(btx_pkg::REG_PITCH,  {$urandom} << 13 | ph_p[ph]);
            csr_write(btx_pkg::REG_PIXEL,  {$urandom} << 3 | ph_b[ph]);
         end
         if (ph < 3)      begin send_idle_pct = 19; recv_idle_pct = 88; end
         else if (ph < 5) begin send_idle_pct = 88; recv_idle_pct = 19; end
         else             begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         // every byte a sample may touch gets written before any sample
         region = ((cfg_height == 0 ? 1 : cfg_height) - 1) * cfg_pitch
                + ((cfg_width == 0 ? 1 : cfg_width) - 1) * cfg_pixel + 3;
         for (int a = 0; a < region; a++) pend_q.push_back(mk_write(18'(a), 8'($urandom)));
         if (ph == 1) begin
            pend_q.push_back(mk_write(18'h3FFFF, 8'hFF));
            pend_q.push_back(mk_write(18'h00000, 8'hFF));
            pend_q.push_back(mk_write(18'h00001, 8'h00));
            pend_q.push_back(mk_sample(17'd0, 17'd0));
            pend_q.push_back(mk_sample(17'd65536, 17'd65536));
            pend_q.push_back(mk_sample(17'h1FFFF, 17'h1FFFF));
            pend_q.push_back(mk_sample(17'd32768, 17'd0));
            pend_q.push_back(mk_sample(17'd0, 17'd65535));
            pend_q.push_back(mk_sample(17'd1, 17'd1));
            pend_q.push_back(mk_sample(17'd49152, 17'd16384));
            pend_q.push_back(mk_sample(17'd65535, 17'd65536));
         end
         if (ph == 6) hold_start = 1;
         for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(99) < 70)
               pend_q.push_back(mk_sample(rand_coord(), rand_coord()));
            else if ($urandom_range(1))
               pend_q.push_back(mk_write(18'($urandom_range(region - 1)), 8'($urandom)));
            else
               pend_q.push_back(mk_write(18'($urandom), 8'($urandom)));
         end
      end
      while (pend_q.size() > 0 || req_tvalid || rgb_q.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      done = 1;
      $display("covered %0d settings: %0d texture writes, %0d samples, %0d results",
               NPHASE, n_writes, n_samples, n_results);
      $display("sizes 0 to 2047, pitch 0 to 8191, pixel step 0 to 7, u and v past 1.0");
      if (errors == 0)
         $display("bilinear_texel_sampler test passed");
      else
         $display("bilinear_texel_sampler test failed");
      $finish;
   end
endmodule
